// ===== rtl/lct_pkg.sv =====
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants for the loudest channel trigger.
// ----------------------------------------------------------------------------
package lct_pkg;

    // Fixed field widths of the item and result ports.
    localparam int OPCODE_W    = 1;
    localparam int SAMPLE_IN_W = 12;
    localparam int DIR_W       = 2;
    localparam int LEVEL_W     = 12;

    // Configuration register widths.
    localparam int THRESH_W  = 12;
    localparam int WINDOW_W  = 10;
    localparam int LOCKOUT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT   = 2'd2;

    // Configuration reset values.
    localparam logic [THRESH_W-1:0]  THRESHOLD_RST = 12'd300;
    localparam logic [WINDOW_W-1:0]  WINDOW_RST    = 10'd100;
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST   = 16'd1000;

    // Item kinds.
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_TICK   = 1'b1;

    typedef struct packed {
        logic [THRESH_W-1:0]  threshold;
        logic [WINDOW_W-1:0]  window;
        logic [LOCKOUT_W-1:0] lockout;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic               triggered;
        logic [DIR_W-1:0]   direction;
        logic [LEVEL_W-1:0] level;
    } t_result;

endpackage

// ===== rtl/lct_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lct_cfg_regs
// Configuration registers written through a plain write port.
// ----------------------------------------------------------------------------
module lct_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lct_pkg::t_cfg                  o_cfg
);
    import lct_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= THRESHOLD_RST;
            r_cfg.window    <= WINDOW_RST;
            r_cfg.lockout   <= LOCKOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_THRESHOLD: r_cfg.threshold <= i_cfg_data[THRESH_W-1:0];
                REG_WINDOW:    r_cfg.window    <= i_cfg_data[WINDOW_W-1:0];
                REG_LOCKOUT:   r_cfg.lockout   <= i_cfg_data[LOCKOUT_W-1:0];
                default: begin
                    // Writes to unused indexes are ignored.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/lct_core.sv =====
// ----------------------------------------------------------------------------
// lct_core
// Window min/max tracking, best channel selection and lockout counter.
// ----------------------------------------------------------------------------
module lct_core #(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [lct_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [lct_pkg::SAMPLE_IN_W-1:0] i_sample_value,
    input  lct_pkg::t_cfg                   i_cfg,
    output lct_pkg::t_result                o_result
);
    import lct_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SB   = SAMPLE_BITS;
    localparam int WIDE = (SB > SAMPLE_IN_W) ? SB : SAMPLE_IN_W;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

    logic [SB-1:0]        r_window_min, n_window_min;
    logic [SB-1:0]        r_window_max, n_window_max;
    logic [WINDOW_W-1:0]  r_sample_index, n_sample_index;
    logic [CH_W-1:0]      r_channel, n_channel;
    logic [SB-1:0]        r_best_level, n_best_level;
    logic [CH_W-1:0]      r_best_channel, n_best_channel;
    logic [LOCKOUT_W-1:0] r_lockout_left, n_lockout_left;

    logic [WIDE-1:0]     sample_ext;
    logic [SB-1:0]       sample;
    logic [SB-1:0]       upd_max, upd_min, level;
    logic [WINDOW_W-1:0] index_inc;
    logic                window_done;
    logic                better;
    logic [SB-1:0]       scan_level;
    logic [CH_W-1:0]     scan_channel;
    logic                trig;
    logic [WIDE-1:0]     level_ext, thresh_ext;
    logic [CH_W+1:0]     dir_ext;

    always_comb begin
        sample_ext  = WIDE'(i_sample_value);
        sample      = sample_ext[SB-1:0];
        upd_max     = (sample > r_window_max) ? sample : r_window_max;
        upd_min     = (sample < r_window_min) ? sample : r_window_min;
        index_inc   = r_sample_index + 1'b1;
        // A window of zero closes on its first sample, as one of one would.
        window_done = (index_inc >= i_cfg.window);
        level       = (upd_max >= upd_min) ? (upd_max - upd_min) : '0;
        better      = (level > r_best_level);
        scan_level   = better ? level : r_best_level;
        scan_channel = better ? r_channel : r_best_channel;
        level_ext   = WIDE'(scan_level);
        thresh_ext  = WIDE'(i_cfg.threshold);
        trig        = (level_ext > thresh_ext);
        dir_ext     = {2'b00, scan_channel};

        n_window_min   = r_window_min;
        n_window_max   = r_window_max;
        n_sample_index = r_sample_index;
        n_channel      = r_channel;
        n_best_level   = r_best_level;
        n_best_channel = r_best_channel;
        n_lockout_left = r_lockout_left;

        o_result.valid     = 1'b0;
        o_result.triggered = trig;
        o_result.direction = dir_ext[DIR_W-1:0];
        o_result.level     = level_ext[LEVEL_W-1:0];

        if (i_opcode == OP_TICK) begin
            if (r_lockout_left != '0) begin
                n_lockout_left = r_lockout_left - 1'b1;
            end
        end else if (r_lockout_left == '0) begin
            n_window_max   = upd_max;
            n_window_min   = upd_min;
            n_sample_index = index_inc;
            if (window_done) begin
                n_window_max   = '0;
                n_window_min   = '1;
                n_sample_index = '0;
                if (r_channel == LAST_CH) begin
                    o_result.valid = 1'b1;
                    n_channel      = '0;
                    n_best_level   = '0;
                    n_best_channel = '0;
                    if (trig) begin
                        n_lockout_left = i_cfg.lockout;
                    end
                end else begin
                    n_channel      = r_channel + 1'b1;
                    n_best_level   = scan_level;
                    n_best_channel = scan_channel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_min   <= '1;
            r_window_max   <= '0;
            r_sample_index <= '0;
            r_channel      <= '0;
            r_best_level   <= '0;
            r_best_channel <= '0;
            r_lockout_left <= '0;
        end else if (i_fire) begin
            r_window_min   <= n_window_min;
            r_window_max   <= n_window_max;
            r_sample_index <= n_sample_index;
            r_channel      <= n_channel;
            r_best_level   <= n_best_level;
            r_best_channel <= n_best_channel;
            r_lockout_left <= n_lockout_left;
        end
    end

    // A result only closes the last channel's window.
    a_result_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.valid) |-> (r_channel == LAST_CH))
        else $error("result produced before the last channel window");

    // After a result the scan restarts from the first channel with no best level.
    a_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.valid) |=> (r_channel == '0 && r_best_level == '0))
        else $error("scan state not cleared after a result");

    // A sample taken during a lockout leaves the window untouched.
    a_lockout_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_opcode == OP_SAMPLE && r_lockout_left != '0)
        |=> ($stable(r_sample_index) && $stable(r_window_max) && $stable(r_window_min)))
        else $error("sample changed window state during lockout");

    // A triggered result loads the lockout counter.
    a_lockout_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.valid && o_result.triggered)
        |=> (r_lockout_left == $past(i_cfg.lockout)))
        else $error("lockout not loaded after a trigger");

endmodule

// ===== rtl/loudest_channel_trigger_top.sv =====
// ----------------------------------------------------------------------------
// loudest_channel_trigger_top
// Peak-to-peak loudest channel detector with threshold trigger and lockout.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the input is not stalled: each
// item is either an ADC sample of the channel being scanned or a time tick. An
// accepted item is held in an input register, then the window, best-channel and
// lockout state is updated by a single compare-and-subtract pass and any
// result, made by the item that closes the last channel window, lands in the
// output register. The output register decouples the two sides: while a result
// waits to be taken, the input register still empties into the state as soon
// as the output register frees, and input stall rises only when the input
// register is full and the output is stalled with a result pending.
// Configuration writes take effect on the next cycle and are meant to be done
// while no item is in flight.
// ----------------------------------------------------------------------------
module loudest_channel_trigger_top #(
    parameter int CHANNELS    = 4,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Item channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [lct_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [lct_pkg::SAMPLE_IN_W-1:0] i_sample_value,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_triggered,
    output logic [lct_pkg::DIR_W-1:0]       o_direction,
    output logic [lct_pkg::LEVEL_W-1:0]     o_loudest_level,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [lct_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lct_pkg::*;

    t_cfg    cfg;
    t_result result;

    // Input register.
    logic                   r_s1_valid;
    logic [OPCODE_W-1:0]    r_s1_opcode;
    logic [SAMPLE_IN_W-1:0] r_s1_sample;

    // Output register.
    logic               r_out_valid;
    logic               r_out_triggered;
    logic [DIR_W-1:0]   r_out_direction;
    logic [LEVEL_W-1:0] r_out_level;

    logic advance;
    logic fire;
    logic in_take;

    // The pipeline moves whenever the output register is empty or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    lct_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lct_core #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_opcode       (r_s1_opcode),
        .i_sample_value (r_s1_sample),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || advance) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_opcode <= i_opcode;
            r_s1_sample <= i_sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && result.valid) begin
            r_out_triggered <= result.triggered;
            r_out_direction <= result.direction;
            r_out_level     <= result.level;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_triggered     = r_out_triggered;
    assign o_direction     = r_out_direction;
    assign o_loudest_level = r_out_level;

    // An item in the input register is never lost while the output is stalled.
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_sample)
                                      && $stable(r_s1_opcode)))
        else $error("input register changed while blocked");

    // A result waiting in the output register is not overwritten.
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_level)
                                          && $stable(r_out_direction)))
        else $error("pending result overwritten");

    // Input stall only appears when the output side blocks the pipeline.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

endmodule
